/* rtl/sbmw_pkg.sv */
`timescale 1ns / 1ps

package sbmw_pkg;

   // Field widths
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int REG_W   = 5;
   localparam int COUNT_W = 6;
   localparam int LOAD_W  = 3;

   // Loader and register reset values
   localparam logic [REG_W-1:0]   LOADER_EMPTY  = 5'h10;
   localparam logic [REG_W-1:0]   CONTROL_RESET = 5'h0C;
   localparam logic [REG_W-1:0]   PRG_MODE_SET  = 5'h0C;
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 6'd2;
   localparam logic [COUNT_W-1:0] COUNT_FIXED   = 6'd2;
   localparam logic [LOAD_W-1:0]  LOAD_BITS     = 3'd5;

   // Address region boundaries
   localparam logic [ADDR_W-1:0] CHR_LOW_BASE  = 16'hA000;
   localparam logic [ADDR_W-1:0] CHR_HIGH_BASE = 16'hC000;
   localparam logic [ADDR_W-1:0] PRG_BASE      = 16'hE000;

   // Remainder unit: one dividend bit per step
   localparam int DIV_STEPS = REG_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Program bank modes, control bits 3..2
   typedef enum logic [1:0] {
      MODE_32K_EVEN = 2'd0,
      MODE_32K_ODD  = 2'd1,
      MODE_FIX_LOW  = 2'd2,
      MODE_FIX_HIGH = 2'd3
   } prg_mode_type;

   // Controller to datapath
   typedef struct packed {
      logic apply;      // take the write into the loader and registers
      logic prep;       // latch remainder operands
      logic step;       // one remainder step
      logic last_step;  // final step, update the active bank
      logic emit;       // load the response register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic recompute;  // pending write clears the loader or commits
   } dp_status_type;

endpackage

/* rtl/sbmw_ctrl.sv */
`timescale 1ns / 1ps

module sbmw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sbmw_pkg::dp_status_type status,
   output sbmw_pkg::dp_cmd_type    cmd
);
   import sbmw_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              last_step;
   logic              emit_ok;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign last_step = (step_cnt_ff == STEP_W'(DIV_STEPS - 1));
   assign emit_ok   = !rsp_valid_ff || rsp_ready;

   // Commands decoded from state
   always_comb begin
      cmd           = '0;
      cmd.apply     = accept;
      cmd.prep      = (state_ff == S_PREP);
      cmd.step      = (state_ff == S_DIV);
      cmd.last_step = (state_ff == S_DIV) && last_step;
      cmd.emit      = (state_ff == S_EMIT) && emit_ok;
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = status.recompute ? S_PREP : S_EMIT;
            end
         end
         S_PREP: begin
            step_cnt_in = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (last_step) begin
               step_cnt_in = '0;
               state_in    = S_EMIT;
            end else begin
               step_cnt_in = step_cnt_ff + STEP_W'(1);
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // Step counter only moves while dividing
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (step_cnt_ff == '0))
      else $error("step counter nonzero outside divide");

   // An accepted write goes to operand setup or straight to output
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_PREP || state_ff == S_EMIT))
      else $error("bad state after accept");

   // Last remainder step leads to output
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && last_step) |=> (state_ff == S_EMIT))
      else $error("divide did not end in emit");

   // Never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && rsp_valid_ff && !rsp_ready))
      else $error("response overwritten");
`endif

endmodule

/* rtl/sbmw_datapath.sv */
`timescale 1ns / 1ps

module sbmw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sbmw_pkg::COUNT_W-1:0]        csr_write_data,
   input  logic [sbmw_pkg::ADDR_W-1:0]         req_write_address,
   input  logic [sbmw_pkg::DATA_W-1:0]         req_write_data,
   input  sbmw_pkg::dp_cmd_type                cmd,
   output sbmw_pkg::dp_status_type             status,
   output logic [sbmw_pkg::REG_W-1:0]          rsp_control_value,
   output logic [sbmw_pkg::REG_W-1:0]          rsp_chr_bank_low,
   output logic [sbmw_pkg::REG_W-1:0]          rsp_chr_bank_high,
   output logic [sbmw_pkg::REG_W-1:0]          rsp_prg_bank_select,
   output logic [sbmw_pkg::REG_W-1:0]          rsp_prg_window_bank,
   output logic                                rsp_commit_done
);
   import sbmw_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [REG_W-1:0]   shift_ff;
   logic [LOAD_W-1:0]  bits_loaded_ff;
   logic [REG_W-1:0]   control_ff, chr_low_ff, chr_high_ff, prg_ff, active_ff;
   logic               commit_ff;

   logic [REG_W-1:0]   dividend_ff;
   logic [COUNT_W-1:0] divisor_ff;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic               zero_ff;

   logic [REG_W-1:0]   out_control_ff, out_chr_low_ff, out_chr_high_ff;
   logic [REG_W-1:0]   out_prg_ff, out_active_ff;
   logic               out_commit_ff;

   logic               clear_req;
   logic [REG_W-1:0]   shifted;
   logic [LOAD_W-1:0]  bits_next;
   logic               commit;
   prg_mode_type       mode;
   logic [COUNT_W-1:0] divisor_sel;
   logic [REG_W-1:0]   dividend_sel;
   logic [COUNT_W:0]   trial;

   // Loader decode for the pending write
   assign clear_req = req_write_data[DATA_W-1];
   assign shifted   = {req_write_data[0], shift_ff[REG_W-1:1]};
   assign bits_next = bits_loaded_ff + LOAD_W'(1);
   assign commit    = !clear_req && (bits_next >= LOAD_BITS);
   assign status.recompute = clear_req || commit;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // Serial loader and bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff       <= LOADER_EMPTY;
         bits_loaded_ff <= '0;
         control_ff     <= CONTROL_RESET;
         chr_low_ff     <= '0;
         chr_high_ff    <= '0;
         prg_ff         <= '0;
         commit_ff      <= 1'b0;
      end else if (cmd.apply) begin
         commit_ff <= commit;
         if (clear_req) begin
            shift_ff       <= LOADER_EMPTY;
            bits_loaded_ff <= '0;
            control_ff     <= control_ff | PRG_MODE_SET;
         end else if (commit) begin
            shift_ff       <= LOADER_EMPTY;
            bits_loaded_ff <= '0;
            priority if (req_write_address < CHR_LOW_BASE) begin
               control_ff <= shifted;
            end else if (req_write_address < CHR_HIGH_BASE) begin
               chr_low_ff <= shifted;
            end else if (req_write_address < PRG_BASE) begin
               chr_high_ff <= shifted;
            end else begin
               prg_ff <= shifted;
            end
         end else begin
            shift_ff       <= shifted;
            bits_loaded_ff <= bits_next;
         end
      end
   end

   // Remainder operands from mode and bank count
   assign mode = prg_mode_type'(control_ff[3:2]);

   always_comb begin
      unique case (mode)
         MODE_32K_EVEN, MODE_32K_ODD: begin
            divisor_sel  = count_ff >> 1;
            dividend_sel = prg_ff >> 1;
         end
         MODE_FIX_LOW, MODE_FIX_HIGH: begin
            divisor_sel  = count_ff;
            dividend_sel = prg_ff;
         end
         default: begin
            divisor_sel  = count_ff;
            dividend_sel = prg_ff;
         end
      endcase
   end

   // Restoring remainder, one dividend bit per step
   assign trial = {rem_ff, dividend_ff[REG_W-1]};

   always_comb begin
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = COUNT_W'(trial - {1'b0, divisor_ff});
      end else begin
         rem_in = trial[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         dividend_ff <= dividend_sel;
         divisor_ff  <= divisor_sel;
         rem_ff      <= '0;
         zero_ff     <= (count_ff == COUNT_FIXED) || (mode == MODE_FIX_LOW)
                        || (divisor_sel == '0);
      end else if (cmd.step) begin
         dividend_ff <= dividend_ff << 1;
         rem_ff      <= rem_in;
      end
   end

   // Active bank
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.last_step) begin
         active_ff <= zero_ff ? '0 : rem_in[REG_W-1:0];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_control_ff  <= control_ff;
         out_chr_low_ff  <= chr_low_ff;
         out_chr_high_ff <= chr_high_ff;
         out_prg_ff      <= prg_ff;
         out_active_ff   <= active_ff;
         out_commit_ff   <= commit_ff;
      end
   end

   assign rsp_control_value   = out_control_ff;
   assign rsp_chr_bank_low    = out_chr_low_ff;
   assign rsp_chr_bank_high   = out_chr_high_ff;
   assign rsp_prg_bank_select = out_prg_ff;
   assign rsp_prg_window_bank = out_active_ff;
   assign rsp_commit_done     = out_commit_ff;

`ifndef ASSERT_OFF
   // Loader never holds a full load between writes
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_loaded_ff < LOAD_BITS)
      else $error("loader count out of range");

   // A clearing write always leaves the mode bits set
   a_clear_mode: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && clear_req) |=> (control_ff[3:2] == 2'b11))
      else $error("clear write did not set mode bits");
`endif

endmodule

/* rtl/serial_bank_mapper_write_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_write_address, req_write_data
// rsp       out        rsp_valid / rsp_ready     rsp_control_value .. rsp_commit_done
// csr       in         csr_write_enable          csr_write_data (bank count)
//
// A write that only shifts a bit goes from accept to the response load; one that
// clears the loader or completes a load passes accept, operand setup, 5 remainder
// steps (one dividend bit per step, shared remainder unit) and the response load.
// Reset is synchronous: control 0x0C, other bank registers 0, bank count 2.
// A response waiting on rsp_ready holds the controller in its emit state; one
// new write is taken as soon as the previous result sits in the response register.

module serial_bank_mapper_write_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sbmw_pkg::COUNT_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sbmw_pkg::ADDR_W-1:0]   req_write_address,
   input  logic [sbmw_pkg::DATA_W-1:0]   req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sbmw_pkg::REG_W-1:0]    rsp_control_value,
   output logic [sbmw_pkg::REG_W-1:0]    rsp_chr_bank_low,
   output logic [sbmw_pkg::REG_W-1:0]    rsp_chr_bank_high,
   output logic [sbmw_pkg::REG_W-1:0]    rsp_prg_bank_select,
   output logic [sbmw_pkg::REG_W-1:0]    rsp_prg_window_bank,
   output logic                          rsp_commit_done
);
   import sbmw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   sbmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Loader, bank registers and remainder unit
   sbmw_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_write_address   (req_write_address),
      .req_write_data      (req_write_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_control_value   (rsp_control_value),
      .rsp_chr_bank_low    (rsp_chr_bank_low),
      .rsp_chr_bank_high   (rsp_chr_bank_high),
      .rsp_prg_bank_select (rsp_prg_bank_select),
      .rsp_prg_window_bank (rsp_prg_window_bank),
      .rsp_commit_done     (rsp_commit_done)
   );

endmodule
